@@ hdl/mct_pkg.sv @@
// ----------------------------------------------------------------------------
// Mode controller package
// Shared types, codes, reset values and the transition table.
// ----------------------------------------------------------------------------
package mct_pkg;

	localparam int unsigned MODE_W    = 4;
	localparam int unsigned OUTCOME_W = 3;
	localparam int unsigned MS_W      = 16;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned MODE_COUNT = 11;

	typedef enum logic [MODE_W-1:0] {
		MODE_BOOT     = 4'd0,
		MODE_READY    = 4'd1,
		MODE_IDLE     = 4'd2,
		MODE_THINKING = 4'd3,
		MODE_WRITING  = 4'd4,
		MODE_BUSY     = 4'd5,
		MODE_SUCCESS  = 4'd6,
		MODE_ERROR    = 4'd7,
		MODE_HOTLEAD  = 4'd8,
		MODE_SLEEP    = 4'd9,
		MODE_OFFLINE  = 4'd10
	} mode_t;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_NONE     = 3'd0,
		OUT_ACCEPTED = 3'd1,
		OUT_UNMAPPED = 3'd2,
		OUT_REFUSED  = 3'd3,
		OUT_BOOTDONE = 3'd4,
		OUT_TIMEOUT  = 3'd5
	} outcome_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOOT_TIMEOUT     = 4'd0,
		REG_THINKING_TIMEOUT = 4'd1,
		REG_WRITING_TIMEOUT  = 4'd2,
		REG_BUSY_TIMEOUT     = 4'd3
	} cfg_reg_t;

	localparam logic [MS_W-1:0] BOOT_TIMEOUT_RST     = 16'd1500;
	localparam logic [MS_W-1:0] THINKING_TIMEOUT_RST = 16'd7000;
	localparam logic [MS_W-1:0] WRITING_TIMEOUT_RST  = 16'd5000;
	localparam logic [MS_W-1:0] BUSY_TIMEOUT_RST     = 16'd8000;
	localparam logic [MS_W-1:0] MS_MAX               = '1;

	typedef struct packed {
		logic [MS_W-1:0] boot_timeout;
		logic [MS_W-1:0] thinking_timeout;
		logic [MS_W-1:0] writing_timeout;
		logic [MS_W-1:0] busy_timeout;
	} cfg_t;

	typedef struct packed {
		mode_t           mode;
		logic [MS_W-1:0] elapsed;
		outcome_t        outcome;
	} step_t;

	function automatic logic [MODE_COUNT-1:0] mode_bit(input mode_t m);
		logic [MODE_COUNT-1:0] b;
		b = '0;
		b[m] = 1'b1;
		return b;
	endfunction

	// Set of target modes that may be entered from the given mode.
	function automatic logic [MODE_COUNT-1:0] allowed_to(input mode_t m);
		logic [MODE_COUNT-1:0] a;
		case (m)
			MODE_BOOT:     a = mode_bit(MODE_READY) | mode_bit(MODE_OFFLINE);
			MODE_READY:    a = mode_bit(MODE_IDLE) | mode_bit(MODE_THINKING)
			                 | mode_bit(MODE_BUSY) | mode_bit(MODE_OFFLINE)
			                 | mode_bit(MODE_SLEEP);
			MODE_IDLE:     a = mode_bit(MODE_THINKING) | mode_bit(MODE_WRITING)
			                 | mode_bit(MODE_BUSY) | mode_bit(MODE_SLEEP)
			                 | mode_bit(MODE_OFFLINE) | mode_bit(MODE_HOTLEAD);
			MODE_THINKING: a = mode_bit(MODE_WRITING) | mode_bit(MODE_BUSY)
			                 | mode_bit(MODE_ERROR) | mode_bit(MODE_SUCCESS)
			                 | mode_bit(MODE_IDLE);
			MODE_WRITING:  a = mode_bit(MODE_BUSY) | mode_bit(MODE_ERROR)
			                 | mode_bit(MODE_SUCCESS) | mode_bit(MODE_IDLE);
			MODE_BUSY:     a = mode_bit(MODE_SUCCESS) | mode_bit(MODE_ERROR)
			                 | mode_bit(MODE_IDLE) | mode_bit(MODE_HOTLEAD);
			MODE_SUCCESS:  a = mode_bit(MODE_IDLE) | mode_bit(MODE_READY)
			                 | mode_bit(MODE_OFFLINE);
			MODE_ERROR:    a = mode_bit(MODE_IDLE) | mode_bit(MODE_READY)
			                 | mode_bit(MODE_OFFLINE);
			MODE_HOTLEAD:  a = mode_bit(MODE_BUSY) | mode_bit(MODE_SUCCESS)
			                 | mode_bit(MODE_ERROR) | mode_bit(MODE_IDLE);
			MODE_SLEEP:    a = mode_bit(MODE_READY) | mode_bit(MODE_OFFLINE);
			MODE_OFFLINE:  a = mode_bit(MODE_READY) | mode_bit(MODE_BOOT);
			default:       a = '0;
		endcase
		return a;
	endfunction

endpackage

@@ hdl/mode_controller_with_timeouts.sv @@
// ----------------------------------------------------------------------------
// Mode controller with timeouts
// Eleven-mode controller driven by event and millisecond tick requests.
// ----------------------------------------------------------------------------
// Pipeline: the input register takes the request, the result register takes
// the step output; a stalled result holds the request in the input register.
// Throughput: one request per cycle unless the result stalls.
// Reset: asynchronous; mode is boot, counter zero, timeouts at their defaults,
// both pipeline slots empty.
module mode_controller_with_timeouts (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic [mct_pkg::MODE_W-1:0]       event_code,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [mct_pkg::MODE_W-1:0]       mode,
	output logic [mct_pkg::OUTCOME_W-1:0]    outcome,
	input  logic                             cfg_we,
	input  logic [mct_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mct_pkg::MS_W-1:0]         cfg_data
);

	logic                           valid_s1;
	logic                           action_s1;
	logic [mct_pkg::MODE_W-1:0]     code_s1;
	logic                           advance;
	mct_pkg::cfg_t                  cfg_q;
	mct_pkg::mode_t                 mode_q;
	logic [mct_pkg::MS_W-1:0]       elapsed_q;
	mct_pkg::step_t                 nxt;
	logic                           out_valid_q;
	logic [mct_pkg::MODE_W-1:0]     mode_s2;
	logic [mct_pkg::OUTCOME_W-1:0]  outcome_s2;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			code_s1   <= event_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boot_timeout     <= mct_pkg::BOOT_TIMEOUT_RST;
			cfg_q.thinking_timeout <= mct_pkg::THINKING_TIMEOUT_RST;
			cfg_q.writing_timeout  <= mct_pkg::WRITING_TIMEOUT_RST;
			cfg_q.busy_timeout     <= mct_pkg::BUSY_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mct_pkg::REG_BOOT_TIMEOUT:     cfg_q.boot_timeout     <= cfg_data;
				mct_pkg::REG_THINKING_TIMEOUT: cfg_q.thinking_timeout <= cfg_data;
				mct_pkg::REG_WRITING_TIMEOUT:  cfg_q.writing_timeout  <= cfg_data;
				mct_pkg::REG_BUSY_TIMEOUT:     cfg_q.busy_timeout     <= cfg_data;
				default: ;
			endcase
		end
	end

	mct_step u_step (
		.cur_mode   (mode_q),
		.elapsed    (elapsed_q),
		.action     (action_s1),
		.event_code (code_s1),
		.cfg        (cfg_q),
		.nxt        (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= mct_pkg::MODE_BOOT;
			elapsed_q <= '0;
		end else if (advance) begin
			mode_q    <= nxt.mode;
			elapsed_q <= nxt.elapsed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mode_s2    <= nxt.mode;
			outcome_s2 <= nxt.outcome;
		end
	end

	assign out_valid = out_valid_q;
	assign mode      = mode_s2;
	assign outcome   = outcome_s2;

endmodule

@@ hdl/mct_step.sv @@
// ----------------------------------------------------------------------------
// Mode controller step logic
// Computes the next mode, elapsed counter and outcome for one request.
// ----------------------------------------------------------------------------
module mct_step (
	input  mct_pkg::mode_t                 cur_mode,
	input  logic [mct_pkg::MS_W-1:0]       elapsed,
	input  logic                           action,
	input  logic [mct_pkg::MODE_W-1:0]     event_code,
	input  mct_pkg::cfg_t                  cfg,
	output mct_pkg::step_t                 nxt
);

	logic [mct_pkg::MS_W-1:0]       elapsed_inc;
	logic [mct_pkg::MS_W-1:0]       limit;
	logic [mct_pkg::MODE_COUNT-1:0] allowed;
	logic                           mapped;

	assign mapped      = (event_code < mct_pkg::MODE_W'(mct_pkg::MODE_COUNT));
	assign allowed     = mct_pkg::allowed_to(cur_mode);
	assign elapsed_inc = (elapsed == mct_pkg::MS_MAX) ? elapsed
	                                                  : elapsed + mct_pkg::MS_W'(1);

	always_comb begin
		case (cur_mode)
			mct_pkg::MODE_BOOT:     limit = cfg.boot_timeout;
			mct_pkg::MODE_THINKING: limit = cfg.thinking_timeout;
			mct_pkg::MODE_WRITING:  limit = cfg.writing_timeout;
			mct_pkg::MODE_BUSY:     limit = cfg.busy_timeout;
			default:                limit = '0;
		endcase
	end

	always_comb begin
		nxt.mode    = cur_mode;
		nxt.elapsed = elapsed;
		nxt.outcome = mct_pkg::OUT_NONE;
		if (!action) begin
			if (!mapped) begin
				nxt.outcome = mct_pkg::OUT_UNMAPPED;
			end else if ((event_code != cur_mode) && allowed[event_code]) begin
				nxt.mode    = mct_pkg::mode_t'(event_code);
				nxt.elapsed = '0;
				nxt.outcome = mct_pkg::OUT_ACCEPTED;
			end else begin
				nxt.outcome = mct_pkg::OUT_REFUSED;
			end
		end else begin
			nxt.elapsed = elapsed_inc;
			if ((limit != '0) && (elapsed_inc >= limit)) begin
				nxt.elapsed = '0;
				if (cur_mode == mct_pkg::MODE_BOOT) begin
					nxt.mode    = mct_pkg::MODE_READY;
					nxt.outcome = mct_pkg::OUT_BOOTDONE;
				end else begin
					nxt.mode    = mct_pkg::MODE_IDLE;
					nxt.outcome = mct_pkg::OUT_TIMEOUT;
				end
			end
		end
	end

endmodule

@@ hdl/mct_checker.sv @@
// ----------------------------------------------------------------------------
// Mode controller checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module mct_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [mct_pkg::MODE_W-1:0]       mode,
	input logic [mct_pkg::OUTCOME_W-1:0]    outcome
);

	// A stalled result holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mode) && $stable(outcome))
		else $error("stalled result changed");

	// Input back-pressure only comes from a stalled result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

	// Boot completion always lands in ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == mct_pkg::OUT_BOOTDONE) |-> mode == mct_pkg::MODE_READY)
		else $error("boot completion not in ready");

	// A timeout always falls back to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == mct_pkg::OUT_TIMEOUT) |-> mode == mct_pkg::MODE_IDLE)
		else $error("timeout not in idle");

	// Results carry legal codes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mode <= mct_pkg::MODE_W'(mct_pkg::MODE_OFFLINE))
		           && (outcome <= mct_pkg::OUTCOME_W'(mct_pkg::OUT_TIMEOUT)))
		else $error("illegal result code");

endmodule

bind mode_controller_with_timeouts mct_checker u_mct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.mode      (mode),
	.outcome   (outcome)
);

@@ tb/mode_controller_with_timeouts_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mode controller with timeouts: testbench
// Drives event and tick requests through the valid/ready handshake under
// several idling mixes and checks every result against an in-bench model of
// the transition table, the millisecond counter and the timeout registers.
// ----------------------------------------------------------------------------
module mode_controller_with_timeouts_tb;

	localparam bit ACT_EVENT = 1'b0;
	localparam bit ACT_TICK  = 1'b1;
	localparam logic [mct_pkg::MODE_W-1:0] CODE_UNMAPPED_FIRST = 4'd11;
	localparam logic [mct_pkg::MODE_W-1:0] CODE_UNMAPPED_LAST  = 4'd15;
	localparam logic [mct_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd4;
	localparam logic [mct_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = 4'd15;
	localparam int STALL_LIMIT     = 5000;
	localparam int MAX_REPORTS     = 50;
	localparam int PHASE_REQUESTS  = 225;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int DRAIN_CYCLES    = 4;

	typedef struct {
		mct_pkg::mode_t    mode;
		mct_pkg::outcome_t outcome;
	} mode_result_t;

	class mode_scoreboard;
		mct_pkg::mode_t           cur_mode;
		logic [mct_pkg::MS_W-1:0] elapsed_ms;
		logic [mct_pkg::MS_W-1:0] boot_limit;
		logic [mct_pkg::MS_W-1:0] thinking_limit;
		logic [mct_pkg::MS_W-1:0] writing_limit;
		logic [mct_pkg::MS_W-1:0] busy_limit;
		mode_result_t             expected_q[$];
		int                       n_requests;
		int                       n_errors;
		int                       outcome_count[6];

		function new();
			cur_mode = mct_pkg::MODE_BOOT;
			elapsed_ms = '0;
			boot_limit = mct_pkg::BOOT_TIMEOUT_RST;
			thinking_limit = mct_pkg::THINKING_TIMEOUT_RST;
			writing_limit = mct_pkg::WRITING_TIMEOUT_RST;
			busy_limit = mct_pkg::BUSY_TIMEOUT_RST;
			n_requests = 0;
			n_errors = 0;
			foreach (outcome_count[i]) outcome_count[i] = 0;
		endfunction

		function logic [mct_pkg::MODE_COUNT-1:0] mbit(mct_pkg::mode_t m);
			return {{(mct_pkg::MODE_COUNT-1){1'b0}}, 1'b1} << m;
		endfunction

		function logic [mct_pkg::MODE_COUNT-1:0] legal_targets(mct_pkg::mode_t m);
			case (m)
				mct_pkg::MODE_BOOT:
					return mbit(mct_pkg::MODE_READY) | mbit(mct_pkg::MODE_OFFLINE);
				mct_pkg::MODE_READY:
					return mbit(mct_pkg::MODE_IDLE) | mbit(mct_pkg::MODE_THINKING)
					     | mbit(mct_pkg::MODE_BUSY) | mbit(mct_pkg::MODE_OFFLINE)
					     | mbit(mct_pkg::MODE_SLEEP);
				mct_pkg::MODE_IDLE:
					return mbit(mct_pkg::MODE_THINKING) | mbit(mct_pkg::MODE_WRITING)
					     | mbit(mct_pkg::MODE_BUSY) | mbit(mct_pkg::MODE_SLEEP)
					     | mbit(mct_pkg::MODE_OFFLINE) | mbit(mct_pkg::MODE_HOTLEAD);
				mct_pkg::MODE_THINKING:
					return mbit(mct_pkg::MODE_WRITING) | mbit(mct_pkg::MODE_BUSY)
					     | mbit(mct_pkg::MODE_ERROR) | mbit(mct_pkg::MODE_SUCCESS)
					     | mbit(mct_pkg::MODE_IDLE);
				mct_pkg::MODE_WRITING:
					return mbit(mct_pkg::MODE_BUSY) | mbit(mct_pkg::MODE_ERROR)
					     | mbit(mct_pkg::MODE_SUCCESS) | mbit(mct_pkg::MODE_IDLE);
				mct_pkg::MODE_BUSY:
					return mbit(mct_pkg::MODE_SUCCESS) | mbit(mct_pkg::MODE_ERROR)
					     | mbit(mct_pkg::MODE_IDLE) | mbit(mct_pkg::MODE_HOTLEAD);
				mct_pkg::MODE_SUCCESS:
					return mbit(mct_pkg::MODE_IDLE) | mbit(mct_pkg::MODE_READY)
					     | mbit(mct_pkg::MODE_OFFLINE);
				mct_pkg::MODE_ERROR:
					return mbit(mct_pkg::MODE_IDLE) | mbit(mct_pkg::MODE_READY)
					     | mbit(mct_pkg::MODE_OFFLINE);
				mct_pkg::MODE_HOTLEAD:
					return mbit(mct_pkg::MODE_BUSY) | mbit(mct_pkg::MODE_SUCCESS)
					     | mbit(mct_pkg::MODE_ERROR) | mbit(mct_pkg::MODE_IDLE);
				mct_pkg::MODE_SLEEP:
					return mbit(mct_pkg::MODE_READY) | mbit(mct_pkg::MODE_OFFLINE);
				mct_pkg::MODE_OFFLINE:
					return mbit(mct_pkg::MODE_READY) | mbit(mct_pkg::MODE_BOOT);
				default:
					return '0;
			endcase
		endfunction

		function mct_pkg::mode_t pick_legal_target();
			logic [mct_pkg::MODE_COUNT-1:0] mask;
			mct_pkg::mode_t options[$];
			mask = legal_targets(cur_mode);
			for (int i = 0; i < mct_pkg::MODE_COUNT; i++)
				if (mask[i]) options.push_back(mct_pkg::mode_t'(i));
			return options[$urandom_range(options.size() - 1)];
		endfunction

		function void write_config(logic [mct_pkg::CFG_IDX_W-1:0] idx,
		                           logic [mct_pkg::MS_W-1:0] value);
			case (idx)
				mct_pkg::REG_BOOT_TIMEOUT:     boot_limit = value;
				mct_pkg::REG_THINKING_TIMEOUT: thinking_limit = value;
				mct_pkg::REG_WRITING_TIMEOUT:  writing_limit = value;
				mct_pkg::REG_BUSY_TIMEOUT:     busy_limit = value;
				default: ;
			endcase
		endfunction

		function void note_request(bit act, logic [mct_pkg::MODE_W-1:0] code);
			mode_result_t                   r;
			logic [mct_pkg::MODE_COUNT-1:0] mask;
			logic [mct_pkg::MS_W-1:0]       limit;
			r.outcome = mct_pkg::OUT_NONE;
			if (act == ACT_EVENT) begin
				mask = legal_targets(cur_mode);
				if (code >= mct_pkg::MODE_COUNT) begin
					r.outcome = mct_pkg::OUT_UNMAPPED;
				end else if (mct_pkg::mode_t'(code) != cur_mode && mask[code]) begin
					cur_mode = mct_pkg::mode_t'(code);
					elapsed_ms = '0;
					r.outcome = mct_pkg::OUT_ACCEPTED;
				end else begin
					r.outcome = mct_pkg::OUT_REFUSED;
				end
			end else begin
				if (elapsed_ms != mct_pkg::MS_MAX)
					elapsed_ms = elapsed_ms + 1'b1;
				case (cur_mode)
					mct_pkg::MODE_BOOT:     limit = boot_limit;
					mct_pkg::MODE_THINKING: limit = thinking_limit;
					mct_pkg::MODE_WRITING:  limit = writing_limit;
					mct_pkg::MODE_BUSY:     limit = busy_limit;
					default:                limit = '0;
				endcase
				if (limit != '0 && elapsed_ms >= limit) begin
					if (cur_mode == mct_pkg::MODE_BOOT) begin
						cur_mode = mct_pkg::MODE_READY;
						r.outcome = mct_pkg::OUT_BOOTDONE;
					end else begin
						cur_mode = mct_pkg::MODE_IDLE;
						r.outcome = mct_pkg::OUT_TIMEOUT;
					end
					elapsed_ms = '0;
				end
			end
			r.mode = cur_mode;
			expected_q.push_back(r);
			outcome_count[r.outcome]++;
			n_requests++;
		endfunction

		function void check_result(logic [mct_pkg::MODE_W-1:0] got_mode,
		                           logic [mct_pkg::OUTCOME_W-1:0] got_outcome);
			mode_result_t r;
			if (expected_q.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("%0t: unexpected result mode=%0d outcome=%0d", $time,
					         got_mode, got_outcome);
				return;
			end
			r = expected_q.pop_front();
			if (got_mode !== r.mode || got_outcome !== r.outcome) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display({"%0t: mismatch: expected mode=%0d outcome=%0d, ",
					          "got mode=%0d outcome=%0d"},
					         $time, r.mode, r.outcome, got_mode, got_outcome);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic                          action;
	logic [mct_pkg::MODE_W-1:0]    event_code;
	logic                          out_valid;
	logic                          out_ready;
	logic [mct_pkg::MODE_W-1:0]    mode;
	logic [mct_pkg::OUTCOME_W-1:0] outcome;
	logic                          cfg_we;
	logic [mct_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mct_pkg::MS_W-1:0]      cfg_data;

	mode_scoreboard sb = new();
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_off_request = 0;
	int quiet_cycles = 0;

	mode_controller_with_timeouts u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.event_code (event_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mode       (mode),
		.outcome    (outcome),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_request != 0) begin
				n = hold_off_request;
				hold_off_request = 0;
				out_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(mode, outcome);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
				         STALL_LIMIT, sb.pending());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	// with valid still high, so the caller either sends again or lowers it.
	task automatic send_request(bit act, logic [mct_pkg::MODE_W-1:0] code);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		event_code <= code;
		do @(posedge clk); while (!in_ready);
		sb.note_request(act, code);
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_request(ACT_TICK, mct_pkg::MODE_W'($urandom_range(15)));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic program_timeouts(logic [mct_pkg::MS_W-1:0] boot_ms,
	                                logic [mct_pkg::MS_W-1:0] thinking_ms,
	                                logic [mct_pkg::MS_W-1:0] writing_ms,
	                                logic [mct_pkg::MS_W-1:0] busy_ms);
		logic [mct_pkg::CFG_IDX_W-1:0] idx[5];
		logic [mct_pkg::MS_W-1:0]      value[5];
		idx = '{mct_pkg::REG_BOOT_TIMEOUT, mct_pkg::REG_THINKING_TIMEOUT,
		        mct_pkg::REG_WRITING_TIMEOUT, mct_pkg::REG_BUSY_TIMEOUT,
		        $urandom_range(1) ? REG_SPARE_LAST : REG_SPARE_FIRST};
		value = '{boot_ms, thinking_ms, writing_ms, busy_ms,
		          mct_pkg::MS_W'($urandom_range(16'hffff))};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= value[i];
			@(negedge clk);
			sb.write_config(idx[i], value[i]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [mct_pkg::MS_W-1:0] pick_timeout();
		int r;
		r = $urandom_range(99);
		if (r < 12) return '0;
		if (r < 20) return mct_pkg::MS_MAX;
		if (r < 25) return mct_pkg::MS_W'($urandom_range(16'hffff));
		if (r < 35) return mct_pkg::MS_W'(1);
		return mct_pkg::MS_W'($urandom_range(2, 14));
	endfunction

	// Mostly legal moves and tick bursts long enough to reach the short timeouts,
	// with some refused and unmapped events mixed in.
	task automatic send_random_unit(output int sent);
		int r;
		int burst;
		r = $urandom_range(99);
		sent = 1;
		if (r < 45) begin
			burst = $urandom_range(1, 16);
			repeat (burst) send_tick();
			sent = burst;
		end else if (r < 80) begin
			send_request(ACT_EVENT, sb.pick_legal_target());
		end else if (r < 90) begin
			send_request(ACT_EVENT,
			             mct_pkg::MODE_W'($urandom_range(mct_pkg::MODE_COUNT - 1)));
		end else if (r < 95) begin
			send_request(ACT_EVENT, sb.cur_mode);
		end else begin
			send_request(ACT_EVENT, mct_pkg::MODE_W'($urandom_range(CODE_UNMAPPED_FIRST,
			                                                       CODE_UNMAPPED_LAST)));
		end
	endtask

	initial begin
		int sent;
		int done;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = 1'b0;
		event_code = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(ACT_EVENT, CODE_UNMAPPED_LAST);
		send_request(ACT_EVENT, CODE_UNMAPPED_FIRST);
		send_request(ACT_EVENT, mct_pkg::MODE_BOOT);
		send_request(ACT_EVENT, mct_pkg::MODE_IDLE);
		send_tick();
		wait_drained();
		program_timeouts(16'd3, 16'd3, 16'd2, 16'd4);
		repeat (2) send_tick();
		send_request(ACT_EVENT, mct_pkg::MODE_THINKING);
		repeat (3) send_tick();
		send_request(ACT_EVENT, mct_pkg::MODE_WRITING);
		repeat (2) send_tick();
		send_request(ACT_EVENT, mct_pkg::MODE_BUSY);
		repeat (4) send_tick();
		send_request(ACT_EVENT, mct_pkg::MODE_OFFLINE);
		send_request(ACT_EVENT, mct_pkg::MODE_BOOT);
		wait_drained();

		for (int round = 0; round < 2; round++) begin
			for (int phase = 0; phase < 4; phase++) begin
				case (phase)
					0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
					1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
					2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
					default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
				endcase
				program_timeouts(pick_timeout(), pick_timeout(), pick_timeout(), pick_timeout());
				done = 0;
				if (round == 0 && phase == 0) begin
					hold_off_request = HOLD_OFF_CYCLES;
					while (done < 40) begin
						send_random_unit(sent);
						done += sent;
					end
				end
				while (done < PHASE_REQUESTS) begin
					send_random_unit(sent);
					done += sent;
				end
				wait_drained();
			end
		end

		program_timeouts(mct_pkg::BOOT_TIMEOUT_RST, mct_pkg::THINKING_TIMEOUT_RST,
		                 mct_pkg::WRITING_TIMEOUT_RST, mct_pkg::BUSY_TIMEOUT_RST);
		repeat (DRAIN_CYCLES * 2) @(negedge clk);

		$display("Sent %0d requests under four idling mixes, random timeouts and a long stall.",
		         sb.n_requests);
		$display({"Outcomes: %0d none, %0d accepted, %0d unmapped, %0d refused, ",
		          "%0d boot complete, %0d timeout to idle; %0d mismatches."},
		         sb.outcome_count[mct_pkg::OUT_NONE], sb.outcome_count[mct_pkg::OUT_ACCEPTED],
		         sb.outcome_count[mct_pkg::OUT_UNMAPPED], sb.outcome_count[mct_pkg::OUT_REFUSED],
		         sb.outcome_count[mct_pkg::OUT_BOOTDONE], sb.outcome_count[mct_pkg::OUT_TIMEOUT],
		         sb.n_errors);
		if (sb.n_errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ mode_controller_with_timeouts.f @@
hdl/mct_pkg.sv
hdl/mct_step.sv
hdl/mode_controller_with_timeouts.sv
hdl/mct_checker.sv
tb/mode_controller_with_timeouts_tb.sv
